[hw/rtl/two_button_debounce_press_classifier_macros.svh]
// Assertion macros shared by the debounce and press classifier RTL.
`ifndef TWO_BUTTON_DEBOUNCE_PRESS_CLASSIFIER_MACROS_SVH
`define TWO_BUTTON_DEBOUNCE_PRESS_CLASSIFIER_MACROS_SVH

// Checks a property on every rising edge of clk while out of reset.
`define TBDPC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tbdpc assertion failed");

// Checks that a condition never holds.
`define TBDPC_NEVER(lbl, cond) \
    `TBDPC_ASSERT(lbl, !(cond))

`endif

[hw/rtl/tbdpc_pkg.sv]
// Package with types and constants of the two-button debounce and press classifier.
`timescale 1ns / 1ps
package tbdpc_pkg;

    // Width of the internal timestamp arithmetic; time differences wrap at this width.
    localparam int TIME_BITS = 32;
    localparam int THR_BITS  = 16;
    localparam int CFG_IDX_BITS = 2;

    typedef logic [TIME_BITS-1:0] tstamp_t;
    typedef logic [THR_BITS-1:0]  thr_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_LONG_PRESS = 2'd1,
        CFG_COMBO_MIN  = 2'd2
    } cfg_idx_t;

    localparam thr_t DEBOUNCE_RESET   = 16'd30;
    localparam thr_t LONG_PRESS_RESET = 16'd1000;
    localparam thr_t COMBO_MIN_RESET  = 16'd500;

    // One poll word.
    typedef struct packed {
        logic        pin_left;
        logic        pin_right;
        logic [31:0] now_ms;
        logic        clear_edges;
    } in_word_t;

    // One result word.
    typedef struct packed {
        logic        short_left;
        logic        long_left;
        logic        short_right;
        logic        long_right;
        logic        held_left;
        logic        held_right;
        logic [31:0] held_ms_left;
        logic [31:0] held_ms_right;
        logic [31:0] combo_ms;
    } out_word_t;

    // Thresholds the per-button logic needs.
    typedef struct packed {
        thr_t debounce_ms;
        thr_t long_press_ms;
    } btn_cfg_t;

    // Per-button poll result.
    typedef struct packed {
        logic    short_pulse;
        logic    long_pulse;
        logic    held;
        tstamp_t held_ms;
        tstamp_t press_time;
    } btn_res_t;

endpackage

[hw/rtl/two_button_debounce_press_classifier.sv]
// Two-button debounce and press classifier top level with word handshakes.
// Every poll word yields exactly one result word. A poll word is registered on
// input, evaluated against the per-button state once the output register is
// free and written to the output register; a new word can be taken in every
// cycle while the output is drained. Both button units update their state on
// the edge that writes the result word.
// Thresholds reset to 30 ms debounce, 1000 ms long press and 500 ms combo
// minimum; write them only while no word is in flight.
`timescale 1ns / 1ps
module two_button_debounce_press_classifier
    import tbdpc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  in_word_t                in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output out_word_t               out_data,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_addr,
    input  thr_t                    cfg_wdata
);

`include "two_button_debounce_press_classifier_macros.svh"

    thr_t      debounce_reg;
    thr_t      long_press_reg;
    thr_t      combo_min_reg;
    logic      in_vld_reg;
    in_word_t  in_reg;
    logic      out_vld_reg;
    out_word_t out_reg;
    out_word_t out_next;

    logic      advance;
    tstamp_t   now;
    btn_cfg_t  btn_cfg;
    btn_res_t  res_left;
    btn_res_t  res_right;
    tstamp_t   combo_start;
    tstamp_t   combo_hold;
    tstamp_t   combo_val;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
            combo_min_reg  <= COMBO_MIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_DEBOUNCE:   debounce_reg   <= cfg_wdata;
                CFG_LONG_PRESS: long_press_reg <= cfg_wdata;
                CFG_COMBO_MIN:  combo_min_reg  <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Handshake: the input stage moves whenever the output register is free.
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || !out_vld_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end
    end

    assign now             = tstamp_t'(in_reg.now_ms);
    assign btn_cfg.debounce_ms   = debounce_reg;
    assign btn_cfg.long_press_ms = long_press_reg;

    // Per-button debounce and classification.
    tbdpc_button u_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (advance),
        .pressed (!in_reg.pin_left),
        .now     (now),
        .clear   (in_reg.clear_edges),
        .cfg     (btn_cfg),
        .res     (res_left)
    );

    tbdpc_button u_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (advance),
        .pressed (!in_reg.pin_right),
        .now     (now),
        .clear   (in_reg.clear_edges),
        .cfg     (btn_cfg),
        .res     (res_right)
    );

    // Combo time counts from the later press; a press in the future gives zero.
    always_comb
    begin
        combo_start = (res_right.press_time > res_left.press_time)
                      ? res_right.press_time : res_left.press_time;
        combo_hold  = now - combo_start;
        combo_val   = '0;
        if (res_left.held && res_right.held && (now >= combo_start)
            && (combo_hold >= tstamp_t'(combo_min_reg)))
        begin
            combo_val = combo_hold;
        end
    end

    // Assemble the result word.
    always_comb
    begin
        out_next.short_left    = res_left.short_pulse;
        out_next.long_left     = res_left.long_pulse;
        out_next.short_right   = res_right.short_pulse;
        out_next.long_right    = res_right.long_pulse;
        out_next.held_left     = res_left.held;
        out_next.held_right    = res_right.held;
        out_next.held_ms_left  = 32'(res_left.held_ms);
        out_next.held_ms_right = 32'(res_right.held_ms);
        out_next.combo_ms      = 32'(combo_val);
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    // A button cannot complete a short press and fire a long press on the same poll.
    `TBDPC_NEVER(a_left_short_long, out_vld_reg && out_reg.short_left && out_reg.long_left)
    `TBDPC_NEVER(a_right_short_long, out_vld_reg && out_reg.short_right && out_reg.long_right)
    // A released button reports no hold time.
    `TBDPC_ASSERT(a_left_held_ms, (out_vld_reg && !out_reg.held_left) |-> (out_reg.held_ms_left == 32'd0))
    // Combo time needs both buttons held.
    `TBDPC_ASSERT(a_combo_both, (out_vld_reg && (out_reg.combo_ms != 32'd0)) |-> (out_reg.held_left && out_reg.held_right))
    // An empty output register never blocks the input.
    `TBDPC_ASSERT(a_ready_when_empty, !out_vld_reg |-> in_ready)

endmodule

[hw/rtl/tbdpc_button.sv]
// Debounce state and short/long press detection for one button.
`timescale 1ns / 1ps
module tbdpc_button
    import tbdpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     pressed,
    input  tstamp_t  now,
    input  logic     clear,
    input  btn_cfg_t cfg,
    output btn_res_t res
);

    logic    sampled_reg, sampled_next;
    logic    debounced_reg, debounced_next;
    tstamp_t change_time_reg, change_time_next;
    tstamp_t press_time_reg, press_time_next;
    logic    long_rep_reg, long_rep_next;

    logic    stable;
    logic    accept;
    logic    new_press;
    tstamp_t held_now;
    logic    long_rep_mid;
    logic    fire_long;
    logic    fire_short;

    // Debounce: a raw change restarts the stability timer.
    always_comb
    begin
        sampled_next     = pressed;
        change_time_next = (pressed != sampled_reg) ? now : change_time_reg;
        stable           = (now - change_time_next) >= tstamp_t'(cfg.debounce_ms);
        accept           = stable && (debounced_reg != sampled_next);
        new_press        = accept && sampled_next;
        debounced_next   = accept ? sampled_next : debounced_reg;
        press_time_next  = new_press ? now : press_time_reg;
        long_rep_mid     = new_press ? 1'b0 : long_rep_reg;
    end

    // Press classification; on a new press the hold time is zero.
    always_comb
    begin
        held_now      = new_press ? '0 : (now - press_time_reg);
        fire_short    = accept && !sampled_next && !long_rep_reg
                        && (held_now < tstamp_t'(cfg.long_press_ms));
        fire_long     = debounced_next && !long_rep_mid
                        && (held_now >= tstamp_t'(cfg.long_press_ms));
        long_rep_next = clear || long_rep_mid || fire_long;

        res.short_pulse = fire_short && !clear;
        res.long_pulse  = fire_long && !clear;
        res.held        = debounced_next;
        res.held_ms     = debounced_next ? held_now : '0;
        res.press_time  = press_time_next;
    end

    // State is updated once per processed poll word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sampled_reg     <= 1'b0;
            debounced_reg   <= 1'b0;
            change_time_reg <= '0;
            press_time_reg  <= '0;
            long_rep_reg    <= 1'b0;
        end
        else if (en)
        begin
            sampled_reg     <= sampled_next;
            debounced_reg   <= debounced_next;
            change_time_reg <= change_time_next;
            press_time_reg  <= press_time_next;
            long_rep_reg    <= long_rep_next;
        end
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the two-button debounce and press classifier.
module tb;
    import tbdpc_pkg::*;

    // Index past the last threshold register; writes to it must be dropped.
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_POLLS = 275;

    typedef struct {
        in_word_t  word;
        bit        zero_first;
        bit        typed;
        out_word_t want;
    } poll_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    in_word_t                in_data;
    logic                    out_valid;
    logic                    out_ready;
    out_word_t               out_data;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_addr;
    thr_t                    cfg_wdata;

    // Local copy of the thresholds and of the per-button state.
    thr_t    deb_ms    = DEBOUNCE_RESET;
    thr_t    long_ms   = LONG_PRESS_RESET;
    thr_t    combo_min = COMBO_MIN_RESET;
    bit      sampled[2]   = '{1'b0, 1'b0};
    bit      stable[2]    = '{1'b0, 1'b0};
    tstamp_t change_at[2] = '{'0, '0};
    tstamp_t press_at[2]  = '{'0, '0};
    bit      long_done[2] = '{1'b0, 1'b0};

    out_word_t awaited_results[$];
    poll_row_t dir_tbl[$];
    int        err_count = 0;
    bit        in_burst  = 1'b0;

    two_button_debounce_press_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // One button: raw change tracking, debounce acceptance and press events.
    function automatic void step_button(input int k, input bit pressed, input tstamp_t now,
                                        output bit got_short, output bit got_long);
        tstamp_t since;
        got_short = 1'b0;
        got_long  = 1'b0;
        if (pressed != sampled[k])
        begin
            sampled[k]   = pressed;
            change_at[k] = now;
        end
        since = now - change_at[k];
        if (since >= tstamp_t'(deb_ms) && stable[k] != sampled[k])
        begin
            stable[k] = sampled[k];
            if (stable[k])
            begin
                press_at[k]  = now;
                long_done[k] = 1'b0;
            end
            else
            begin
                since = now - press_at[k];
                if (!long_done[k] && since < tstamp_t'(long_ms))
                    got_short = 1'b1;
            end
        end
        since = now - press_at[k];
        if (stable[k] && !long_done[k] && since >= tstamp_t'(long_ms))
        begin
            long_done[k] = 1'b1;
            got_long     = 1'b1;
        end
    endfunction

    // Full poll: both buttons, clear request, hold times and combo time.
    function automatic out_word_t classify_poll(input in_word_t w);
        out_word_t r;
        bit        es[2];
        bit        el[2];
        tstamp_t   start;
        tstamp_t   span;
        r = '0;
        step_button(0, !w.pin_left, w.now_ms, es[0], el[0]);
        step_button(1, !w.pin_right, w.now_ms, es[1], el[1]);
        if (w.clear_edges)
        begin
            es = '{1'b0, 1'b0};
            el = '{1'b0, 1'b0};
            long_done = '{1'b1, 1'b1};
        end
        r.short_left    = es[0];
        r.long_left     = el[0];
        r.short_right   = es[1];
        r.long_right    = el[1];
        r.held_left     = stable[0];
        r.held_right    = stable[1];
        r.held_ms_left  = stable[0] ? w.now_ms - press_at[0] : '0;
        r.held_ms_right = stable[1] ? w.now_ms - press_at[1] : '0;
        // The combo counts from the later press; no wrap is allowed here.
        if (stable[0] && stable[1])
        begin
            start = (press_at[1] > press_at[0]) ? press_at[1] : press_at[0];
            if (w.now_ms >= start)
            begin
                span = w.now_ms - start;
                if (span >= tstamp_t'(combo_min))
                    r.combo_ms = span;
            end
        end
        return r;
    endfunction

    function automatic out_word_t ev(input bit sl, input bit ll, input bit sr, input bit lr,
                                     input bit hl, input bit hr);
        out_word_t r;
        r = '0;
        r.short_left  = sl;
        r.long_left   = ll;
        r.short_right = sr;
        r.long_right  = lr;
        r.held_left   = hl;
        r.held_right  = hr;
        return r;
    endfunction

    function automatic poll_row_t row(input bit pl, input bit pr, input tstamp_t now,
                                      input bit clr, input bit zero_first, input bit typed,
                                      input out_word_t want);
        poll_row_t r;
        r.word.pin_left    = pl;
        r.word.pin_right   = pr;
        r.word.now_ms      = now;
        r.word.clear_edges = clr;
        r.zero_first       = zero_first;
        r.typed            = typed;
        r.want             = want;
        return r;
    endfunction

    function automatic thr_t pick_threshold();
        case ($urandom_range(0, 3))
            0: return thr_t'($urandom_range(0, 8));
            1: return thr_t'($urandom_range(9, 100));
            2: return thr_t'($urandom_range(100, 2000));
            default: return thr_t'($urandom_range(0, 65535));
        endcase
    endfunction

    // Offers one poll word and records its expected result once accepted.
    task automatic feed_poll(input in_word_t w, input bit typed, input out_word_t want);
        int        gap;
        out_word_t pred;
        gap = in_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        pred = classify_poll(w);
        awaited_results.push_back(typed ? want : pred);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input thr_t v);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        case (idx)
            CFG_DEBOUNCE:   deb_ms    = v;
            CFG_LONG_PRESS: long_ms   = v;
            CFG_COMBO_MIN:  combo_min = v;
            default: ;
        endcase
    endtask

    // Thresholds change only once every poll in flight has come back.
    task automatic set_thresholds(input thr_t d, input thr_t l, input thr_t c);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        write_reg(CFG_DEBOUNCE, d);
        write_reg(CFG_LONG_PRESS, l);
        write_reg(CFG_COMBO_MIN, c);
        write_reg(CFG_UNUSED, thr_t'($urandom()));
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    // Result side: each word taken is compared with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        out_word_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result word with none awaited, expected nothing, actual %h",
                         $time, out_data);
                err_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("short_left", 32'(want.short_left), 32'(out_data.short_left));
                check_field("long_left", 32'(want.long_left), 32'(out_data.long_left));
                check_field("short_right", 32'(want.short_right), 32'(out_data.short_right));
                check_field("long_right", 32'(want.long_right), 32'(out_data.long_right));
                check_field("held_left", 32'(want.held_left), 32'(out_data.held_left));
                check_field("held_right", 32'(want.held_right), 32'(out_data.held_right));
                check_field("held_ms_left", want.held_ms_left, out_data.held_ms_left);
                check_field("held_ms_right", want.held_ms_right, out_data.held_ms_right);
                check_field("combo_ms", want.combo_ms, out_data.combo_ms);
            end
        end
    end

    // Result side back-pressure, with runs of no stalling now and then.
    initial
    begin : drain
        int stall;
        int run_left;
        bit burst;
        out_ready <= 1'b0;
        burst    = 1'b0;
        run_left = 0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (run_left == 0)
            begin
                burst    = ($urandom_range(0, 3) == 0);
                run_left = 40;
            end
            run_left--;
            stall = burst ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
        end
    end

    initial
    begin
        #3_000_000;
        $display("** two_button_debounce_press_classifier: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        poll_row_t   r;
        in_word_t    w;
        tstamp_t     now_t;
        int unsigned step;
        int          sel;
        bit          want_down[2];

        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= CFG_DEBOUNCE;
        cfg_wdata <= '0;
        rst_n     <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed polls at reset thresholds: idle extremes, debounce edge, combo
        // minimum, long press, clear request, short presses, press in the future.
        dir_tbl.push_back(row(1, 1, 32'd0, 0, 0, 1, '0));
        dir_tbl.push_back(row(1, 1, 32'hFFFF_FFFF, 0, 0, 1, '0));
        dir_tbl.push_back(row(0, 1, 32'd100, 0, 0, 1, '0));
        dir_tbl.push_back(row(0, 1, 32'd129, 0, 0, 0, '0));
        dir_tbl.push_back(row(0, 1, 32'd130, 0, 0, 1, ev(0, 0, 0, 0, 1, 0)));
        dir_tbl.push_back(row(0, 0, 32'd140, 0, 0, 0, '0));
        dir_tbl.push_back(row(0, 0, 32'd170, 0, 0, 0, '0));
        dir_tbl.push_back(row(0, 0, 32'd669, 0, 0, 0, '0));
        dir_tbl.push_back(row(0, 0, 32'd670, 0, 0, 0, '0));
        dir_tbl.push_back(row(0, 0, 32'd1130, 0, 0, 0, '0));
        dir_tbl.push_back(row(0, 0, 32'd1170, 1, 0, 0, '0));
        dir_tbl.push_back(row(1, 1, 32'd1200, 0, 0, 0, '0));
        dir_tbl.push_back(row(1, 1, 32'd1230, 0, 0, 0, '0));
        dir_tbl.push_back(row(0, 0, 32'd2000, 0, 0, 0, '0));
        dir_tbl.push_back(row(0, 0, 32'd2030, 0, 0, 0, '0));
        dir_tbl.push_back(row(1, 1, 32'd2100, 0, 0, 0, '0));
        dir_tbl.push_back(row(1, 1, 32'd2130, 0, 0, 0, '0));
        dir_tbl.push_back(row(0, 0, 32'hFFFF_FF00, 0, 0, 0, '0));
        dir_tbl.push_back(row(0, 0, 32'hFFFF_FF20, 0, 0, 0, '0));
        dir_tbl.push_back(row(0, 0, 32'h0000_0100, 0, 0, 0, '0));
        // Zero thresholds: same-poll acceptance, long on the press, no short ever.
        dir_tbl.push_back(row(1, 1, 32'd10, 0, 1, 1, '0));
        dir_tbl.push_back(row(0, 0, 32'd20, 0, 0, 1, ev(0, 1, 0, 1, 1, 1)));
        dir_tbl.push_back(row(0, 0, 32'd25, 0, 0, 0, '0));
        dir_tbl.push_back(row(1, 1, 32'd30, 1, 0, 0, '0));

        foreach (dir_tbl[i])
        begin
            r = dir_tbl[i];
            if (r.zero_first)
            begin
                in_valid <= 1'b0;
                set_thresholds('0, '0, '0);
            end
            feed_poll(r.word, r.typed, r.want);
        end
        in_valid <= 1'b0;

        // Random phases: press and release sequences with bounce, time jumps and noise.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0: set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: set_thresholds('0, '0, '0);
                default: set_thresholds(pick_threshold(), pick_threshold(), pick_threshold());
            endcase
            now_t = ($urandom_range(0, 2) == 0) ? 32'hFFFF_0000 + $urandom_range(0, 65535)
                                                : tstamp_t'($urandom());
            want_down[0] = $urandom_range(0, 1);
            want_down[1] = $urandom_range(0, 1);
            for (int i = 0; i < PHASE_POLLS; i++)
            begin
                if (i % 40 == 0)
                    in_burst = ($urandom_range(0, 3) == 0);
                for (int k = 0; k < 2; k++)
                    if ($urandom_range(0, 7) == 0)
                        want_down[k] = !want_down[k];
                sel = $urandom_range(0, 19);
                if (sel < 5)
                    step = $urandom_range(0, 3);
                else if (sel < 10)
                    step = $urandom_range(0, int'(deb_ms) + 2);
                else if (sel < 16)
                    step = $urandom_range(0, int'(long_ms) / 4 + 4);
                else
                    step = $urandom_range(0, 2 * int'(long_ms) + 100);
                now_t = (sel == 19) ? tstamp_t'($urandom()) : now_t + step;
                w.pin_left    = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1))
                                                            : !want_down[0];
                w.pin_right   = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1))
                                                            : !want_down[1];
                w.now_ms      = now_t;
                w.clear_edges = ($urandom_range(0, 24) == 0);
                feed_poll(w, 1'b0, '0);
            end
            in_valid <= 1'b0;
        end

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (err_count == 0)
            $display("** two_button_debounce_press_classifier: PASSED **");
        else
            $display("** two_button_debounce_press_classifier: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/tbdpc_pkg.sv
hw/rtl/tbdpc_button.sv
hw/rtl/two_button_debounce_press_classifier.sv
tb/sv/tb.sv
